// ===== rtl/weo_pkg.sv =====
// package for the wheel encoder odometry block
// holds the default sizes, register reset value and stream widths; no dependencies
`default_nettype none

package weo_pkg;

  localparam int COUNT_BITS = 14;
  localparam int TURN_BITS  = 24;

  localparam logic [31:0] SCALE_RESET = 32'd411774;

  // cmd codes
  localparam logic CMD_CAPTURE = 1'b0;
  localparam logic CMD_SAMPLE  = 1'b1;

  // result field widths
  localparam int STEP_W    = 15;
  localparam int ANGLE_W   = 14;
  localparam int TURN_W    = 24;
  localparam int PARTIAL_W = 16;
  localparam int DELTA_W   = 41;
  localparam int TOTAL_W   = 64;

  localparam int FIELDS_W = STEP_W + ANGLE_W + TURN_W + PARTIAL_W + DELTA_W + TOTAL_W;
  localparam int M_DATA_W = ((FIELDS_W + 7) / 8) * 8;
  localparam int S_DATA_W = 16;

  // accumulation width for the distance sums, covers the widest turn count
  localparam int ACC_W = 67;

endpackage

`default_nettype wire

// ===== rtl/wheel_encoder_odometry.sv =====
// Wheel encoder odometry: multiturn tracking, angle from zero and distance.
// Registers from input transaction to result valid: input register, tracking
// register, product register, output register holding the distance sums.
// Throughput: one transaction per cycle unless stalled; one-pass tracking update.
// Reset: synchronous; clears all tracking state, sets distance_scale to 411774.
// Depends on weo_pkg.
`default_nettype none

module wheel_encoder_odometry #(
  parameter int COUNT_BITS = weo_pkg::COUNT_BITS,
  parameter int TURN_BITS  = weo_pkg::TURN_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,

  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [31:0]                   cfg_data,      // distance_scale

  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [weo_pkg::S_DATA_W-1:0]  s_axis_tdata,  // raw_frame
  input  wire logic                          s_axis_tuser,  // cmd

  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // step_counts, angle_counts, turn_count, partial_counts, move_distance,
  // total_distance, zero fill
  output logic [weo_pkg::M_DATA_W-1:0]       m_axis_tdata
);

  localparam int CB    = COUNT_BITS;
  localparam int TB    = TURN_BITS;
  localparam int SW    = CB + 2;
  localparam int ACC_W = weo_pkg::ACC_W;

  localparam logic signed [SW-1:0] CNT_FULL = {2'b01, {CB{1'b0}}};
  localparam logic signed [SW-1:0] CNT_HALF = {3'b001, {(CB-1){1'b0}}};
  localparam logic signed [TB-1:0] TURN_MAX = {1'b0, {(TB-1){1'b1}}};
  localparam logic signed [TB-1:0] TURN_MIN = {1'b1, {(TB-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ROUND_HALF = {{(ACC_W-CB){1'b0}}, 1'b1, {(CB-1){1'b0}}};
  localparam logic signed [63:0] TOTAL_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] TOTAL_MIN = {1'b1, {63{1'b0}}};

  // configuration
  logic [31:0] distance_scale;

  // tracking state
  logic [CB-1:0]        zero_pos;
  logic [CB-1:0]        prev_pos;
  logic [CB-1:0]        prev_angle;
  logic signed [SW-1:0] step_sum;
  logic signed [TB-1:0] turns;

  // input stage
  logic          a_valid;
  logic          a_cmd;
  logic [CB-1:0] a_pos;

  // tracking stage
  logic                 b_valid;
  logic                 b_cap;
  logic signed [CB:0]   b_step;
  logic [CB-1:0]        b_angle;
  logic signed [CB:0]   b_dangle;
  logic signed [TB-1:0] b_turns;
  logic signed [SW-1:0] b_sum;
  logic                 b_up;
  logic                 b_dn;

  // multiply stage
  logic                    c_valid;
  logic                    c_cap;
  logic signed [CB:0]      c_step;
  logic [CB-1:0]           c_angle;
  logic signed [TB-1:0]    c_turns;
  logic signed [SW-1:0]    c_sum;
  logic signed [33:0]      c_dscale;
  logic signed [CB+33:0]   c_prod_angle;
  logic signed [TB+32:0]   c_prod_turn;
  logic signed [SW+32:0]   c_prod_sum;

  logic a_ready, b_ready, c_ready, d_ready;

  assign d_ready       = !m_axis_tvalid || m_axis_tready;
  assign c_ready       = !c_valid || d_ready;
  assign b_ready       = !b_valid || c_ready;
  assign a_ready       = !a_valid || b_ready;
  assign s_axis_tready = a_ready && !rst;
  assign cfg_ready     = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_scale <= weo_pkg::SCALE_RESET;
    end else if (cfg_valid) begin
      distance_scale <= cfg_data;
    end
  end

  // tracking update
  logic signed [SW-1:0] diff, step_w, sum_raw, sum_adj;
  logic                 inc, dec, up, dn;
  logic [CB-1:0]        angle;
  logic signed [TB-1:0] turns_next;

  always_comb begin
    diff = signed'({2'b00, a_pos}) - signed'({2'b00, prev_pos});
    if (diff > CNT_HALF) begin
      step_w = diff - CNT_FULL;
    end else if (diff < -CNT_HALF) begin
      step_w = diff + CNT_FULL;
    end else begin
      step_w = diff;
    end
    sum_raw = step_sum + step_w;
    inc     = sum_raw > CNT_FULL;
    dec     = sum_raw < -CNT_FULL;
    up      = inc && (turns != TURN_MAX);
    dn      = dec && (turns != TURN_MIN);
    priority if (inc) begin
      sum_adj = sum_raw - CNT_FULL;
    end else if (dec) begin
      sum_adj = sum_raw + CNT_FULL;
    end else begin
      sum_adj = sum_raw;
    end
    priority if (up) begin
      turns_next = turns + TB'(1);
    end else if (dn) begin
      turns_next = turns - TB'(1);
    end else begin
      turns_next = turns;
    end
    angle = a_pos - zero_pos;
  end

  logic b_load;
  assign b_load = b_ready && a_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_pos   <= '0;
      prev_pos   <= '0;
      prev_angle <= '0;
      step_sum   <= '0;
      turns      <= '0;
    end else if (b_load) begin
      if (a_cmd == weo_pkg::CMD_CAPTURE) begin
        zero_pos   <= a_pos;
        prev_pos   <= a_pos;
        prev_angle <= '0;
        step_sum   <= '0;
        turns      <= '0;
      end else begin
        prev_pos   <= a_pos;
        prev_angle <= angle;
        step_sum   <= sum_adj;
        turns      <= turns_next;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid       <= 1'b0;
      b_valid       <= 1'b0;
      c_valid       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= s_axis_tvalid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (c_ready) begin
        c_valid <= b_valid;
      end
      if (d_ready) begin
        m_axis_tvalid <= c_valid;
      end
    end
  end

  // payload registers
  logic signed [32:0] scale_s;
  assign scale_s = signed'({1'b0, distance_scale});

  always_ff @(posedge clk) begin
    if (a_ready && s_axis_tvalid) begin
      a_cmd <= s_axis_tuser;
      a_pos <= s_axis_tdata[CB-1:0];
    end
    if (b_load) begin
      b_cap    <= (a_cmd == weo_pkg::CMD_CAPTURE);
      b_step   <= step_w[CB:0];
      b_angle  <= angle;
      b_dangle <= signed'({1'b0, angle}) - signed'({1'b0, prev_angle});
      b_turns  <= turns_next;
      b_sum    <= sum_adj;
      b_up     <= up;
      b_dn     <= dn;
    end
    if (c_ready && b_valid) begin
      c_cap        <= b_cap;
      c_step       <= b_step;
      c_angle      <= b_angle;
      c_turns      <= b_turns;
      c_sum        <= b_sum;
      c_prod_angle <= (CB+34)'(b_dangle) * (CB+34)'(scale_s);
      c_prod_turn  <= (TB+33)'(b_turns) * (TB+33)'(scale_s);
      c_prod_sum   <= (SW+33)'(b_sum) * (SW+33)'(scale_s);
      priority if (b_up) begin
        c_dscale <= 34'(scale_s);
      end else if (b_dn) begin
        c_dscale <= -34'(scale_s);
      end else begin
        c_dscale <= '0;
      end
    end
  end

  // distance sums and result packing
  logic signed [ACC_W-1:0] delta_acc, total_acc;
  logic signed [63:0]      total_sat, step64, turns64, sum64;
  logic [63:0]             angle64;
  logic                    total_ovf;
  logic [weo_pkg::M_DATA_W-1:0] result;

  always_comb begin
    delta_acc = ACC_W'(c_dscale)
              + ((ACC_W'(c_prod_angle) + ROUND_HALF) >>> CB);
    total_acc = ACC_W'(c_prod_turn)
              + ((ACC_W'(c_prod_sum) + ROUND_HALF) >>> CB);
    total_ovf = total_acc[ACC_W-1:63] != {(ACC_W-63){total_acc[63]}};
    if (total_ovf) begin
      total_sat = total_acc[ACC_W-1] ? TOTAL_MIN : TOTAL_MAX;
    end else begin
      total_sat = total_acc[63:0];
    end
    step64  = 64'(c_step);
    turns64 = 64'(c_turns);
    sum64   = 64'(c_sum);
    angle64 = 64'(c_angle);
    if (c_cap) begin
      result = '0;
    end else begin
      result = {{(weo_pkg::M_DATA_W - weo_pkg::FIELDS_W){1'b0}},
                total_sat,
                delta_acc[weo_pkg::DELTA_W-1:0],
                sum64[weo_pkg::PARTIAL_W-1:0],
                turns64[weo_pkg::TURN_W-1:0],
                angle64[weo_pkg::ANGLE_W-1:0],
                step64[weo_pkg::STEP_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && c_valid) begin
      m_axis_tdata <= result;
    end
  end

endmodule

`default_nettype wire

// ===== tb/weo_checker.sv =====
// checker for the wheel encoder odometry block: tracks the encoder state, predicts each
// result from the accepted frames and scale writes, and compares the results field by field
// depends on weo_pkg
module weo_checker (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  input  wire logic                         cfg_ready,
  input  wire logic [31:0]                  cfg_data,
  input  wire logic                         s_axis_tvalid,
  input  wire logic                         s_axis_tready,
  input  wire logic [weo_pkg::S_DATA_W-1:0] s_axis_tdata,
  input  wire logic                         s_axis_tuser,
  input  wire logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  input  wire logic [weo_pkg::M_DATA_W-1:0] m_axis_tdata,
  output int                                errors,
  output int                                pending
);
  import weo_pkg::*;

  localparam int     FULL        = 1 << COUNT_BITS;
  localparam int     HALF        = 1 << (COUNT_BITS - 1);
  localparam longint TURN_MAX    = (longint'(1) << (TURN_BITS - 1)) - 1;
  localparam longint TURN_MIN    = -TURN_MAX - 1;

  // fields from the lowest bit up: step, angle, turns, partial, delta, total
  typedef struct packed {
    logic signed [TOTAL_W-1:0]   total;
    logic signed [DELTA_W-1:0]   delta;
    logic signed [PARTIAL_W-1:0] partial;
    logic signed [TURN_W-1:0]    turns;
    logic [ANGLE_W-1:0]          angle;
    logic signed [STEP_W-1:0]    step;
  } odo_result_t;

  logic [31:0]           scale_q16;
  logic [COUNT_BITS-1:0] zero_pos;
  logic [COUNT_BITS-1:0] last_pos;
  logic [COUNT_BITS-1:0] held_angle;
  int                    partial_sum;
  longint                turn_cnt;
  longint                last_turns;
  odo_result_t           odometry_q[$];

  // floor((v + half turn) / full turn)
  function automatic longint round_counts(longint v);
    return (v + HALF) >>> COUNT_BITS;
  endfunction

  function automatic odo_result_t track_frame(logic cmd, logic [S_DATA_W-1:0] frame);
    logic [COUNT_BITS-1:0] pos;
    logic [COUNT_BITS-1:0] angle;
    int                    step;
    longint                scl;
    longint                dturn;
    longint                dangle;
    longint                delta;
    longint                total;
    odo_result_t           r;
    pos = frame[COUNT_BITS-1:0];
    r = '0;
    if (cmd == CMD_CAPTURE) begin
      zero_pos = pos;
      last_pos = pos;
      held_angle = '0;
      partial_sum = 0;
      turn_cnt = 0;
      last_turns = 0;
      return r;
    end
    step = int'(pos) - int'(last_pos);
    if (step > HALF) begin
      step -= FULL;
    end else if (step < -HALF) begin
      step += FULL;
    end
    partial_sum += step;
    angle = pos - zero_pos;
    if (partial_sum > FULL) begin
      if (turn_cnt < TURN_MAX) turn_cnt++;
      partial_sum -= FULL;
    end
    if (partial_sum < -FULL) begin
      if (turn_cnt > TURN_MIN) turn_cnt--;
      partial_sum += FULL;
    end
    scl = {32'd0, scale_q16};
    dturn = turn_cnt - last_turns;
    dangle = int'(angle) - int'(held_angle);
    delta = dturn * scl + round_counts(dangle * scl);
    total = turn_cnt * scl + round_counts(partial_sum * scl);
    last_pos = pos;
    held_angle = angle;
    last_turns = turn_cnt;
    r.step = step[STEP_W-1:0];
    r.angle = angle;
    r.turns = turn_cnt[TURN_W-1:0];
    r.partial = partial_sum[PARTIAL_W-1:0];
    r.delta = delta[DELTA_W-1:0];
    r.total = total;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t %s expected %h got %h", $time, name, want, got);
    end
  endtask

  task automatic check_result(odo_result_t want, logic [M_DATA_W-1:0] data);
    odo_result_t got;
    got = data[FIELDS_W-1:0];
    check_field("step_counts", want.step, got.step);
    check_field("angle_counts", want.angle, got.angle);
    check_field("turn_count", want.turns, got.turns);
    check_field("partial_counts", want.partial, got.partial);
    check_field("move_distance", want.delta, got.delta);
    check_field("total_distance", want.total, got.total);
    check_field("zero fill", '0, data[M_DATA_W-1:FIELDS_W]);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      scale_q16 = SCALE_RESET;
      zero_pos = '0;
      last_pos = '0;
      held_angle = '0;
      partial_sum = 0;
      turn_cnt = 0;
      last_turns = 0;
      odometry_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) scale_q16 = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        odometry_q.push_back(track_frame(s_axis_tuser, s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (odometry_q.size() == 0) begin
          errors++;
          $display("%0t expected no transaction got %h", $time, m_axis_tdata);
        end else begin
          check_result(odometry_q.pop_front(), m_axis_tdata);
        end
      end
    end
    pending = odometry_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// top of the wheel encoder odometry testbench: clock, reset, frame and scale stimulus,
// random gaps and back-pressure, and the verdict
// depends on weo_pkg, wheel_encoder_odometry and weo_checker
module tb_top;
  import weo_pkg::*;

  localparam int   HALF        = 1 << (COUNT_BITS - 1);
  localparam int   LIMIT       = 400000;
  localparam int   PHASES      = 12;
  localparam int   PHASE_ITEMS = 160;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic [31:0]           cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic [S_DATA_W-1:0]   s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tready = 1'b0;
  wire                   cfg_ready;
  wire                   s_axis_tready;
  wire                   m_axis_tvalid;
  wire [M_DATA_W-1:0]    m_axis_tdata;

  int                    errors;
  int                    pending;
  int                    cycles = 0;
  int                    ready_hold = 0;
  int                    wheel_dir = 1;
  bit                    gaps_on = 1'b0;
  bit                    stalls_on = 1'b0;
  logic [COUNT_BITS-1:0] cur_pos = '0;

  wheel_encoder_odometry uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  weo_checker chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .errors       (errors),
    .pending      (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (stalls_on && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      ready_hold <= gap_len();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_frame(logic cmd, logic [S_DATA_W-1:0] frame);
    int gap;
    gap = (gaps_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= frame;
    s_axis_tuser <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // hold the sender until every transaction in flight has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_scale(logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wheel motion with random content, plus captures, jumps and wrap-edge steps
  task automatic random_frame();
    int                  kind;
    int                  step;
    logic                cmd;
    logic [S_DATA_W-1:0] frame;
    kind = $urandom_range(0, 99);
    cmd = CMD_SAMPLE;
    if (kind < 3) begin
      cmd = CMD_CAPTURE;
      frame = 16'($urandom);
    end else if (kind < 10) begin
      frame = 16'($urandom);
    end else begin
      if (kind < 16) begin
        step = HALF + int'($urandom_range(0, 1));
        if ($urandom_range(0, 1) == 1) step = -step;
      end else if (kind < 40) begin
        step = int'($urandom_range(0, 64)) - 32;
      end else begin
        step = wheel_dir * int'($urandom_range(0, HALF));
      end
      frame = {2'($urandom), COUNT_BITS'(int'(cur_pos) + step)};
    end
    cur_pos = frame[COUNT_BITS-1:0];
    send_frame(cmd, frame);
  endtask

  initial begin
    logic [31:0] scale;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // wrap edges at exactly half a turn, upper frame bits set
    send_frame(CMD_CAPTURE, 16'h0000);
    send_frame(CMD_SAMPLE, 16'hFFFF);
    send_frame(CMD_SAMPLE, 16'h1FFF);
    send_frame(CMD_SAMPLE, 16'h3FFF);
    send_frame(CMD_SAMPLE, 16'h0000);
    // partial sum reaches exactly one turn, then passes it
    send_frame(CMD_CAPTURE, 16'h0000);
    send_frame(CMD_SAMPLE, 16'h2000);
    send_frame(CMD_SAMPLE, 16'h3FFF);
    send_frame(CMD_SAMPLE, 16'h0000);
    send_frame(CMD_SAMPLE, 16'h0001);
    // same backward
    send_frame(CMD_CAPTURE, 16'h2000);
    send_frame(CMD_SAMPLE, 16'h0000);
    send_frame(CMD_SAMPLE, 16'h2001);
    send_frame(CMD_SAMPLE, 16'h2000);
    send_frame(CMD_SAMPLE, 16'h1FFF);
    // nonzero zero with angle wrapping below it
    send_frame(CMD_CAPTURE, 16'hC123);
    send_frame(CMD_SAMPLE, 16'h4122);
    send_frame(CMD_SAMPLE, 16'h8123);
    cur_pos = 14'h0123;

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: scale = 32'hFFFF_FFFF;
        1: scale = 32'h0000_0000;
        2: scale = 32'h0000_0001;
        3: scale = SCALE_RESET;
        4: scale = 32'h8000_0000;
        default: scale = $urandom;
      endcase
      write_scale(scale);
      gaps_on = (phase % 3) != 0;
      stalls_on = (phase % 4) != 1;
      wheel_dir = ($urandom_range(0, 1) == 1) ? 1 : -1;
      repeat (PHASE_ITEMS) random_frame();
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/weo_pkg.sv
rtl/wheel_encoder_odometry.sv
tb/weo_checker.sv
tb/tb_top.sv
